/* hdl/assert_macros.svh */
// Assertion helpers used by the timer queue top module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising clock edge, muted while reset is asserted.
`define SOTQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check prop on every rising clock edge, reset included.
`define SOTQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/sotq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sotq_pkg;

  localparam int unsigned DelayW = 32;
  localparam int unsigned TidW   = 8;
  localparam int unsigned PendW  = 5;

  localparam logic ActTick = 1'b0;
  localparam logic ActAdd  = 1'b1;

  typedef struct packed {
    logic [TidW-1:0]   tid;
    logic [DelayW-1:0] delay;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_TWALK,
    ST_IWALK,
    ST_IFIN,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

/* hdl/sotq_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface sotq_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [sotq_pkg::TidW-1:0]   task_id;
  logic [sotq_pkg::DelayW-1:0] delay_ticks;
  logic                        paused;

  modport source (output valid, action, task_id, delay_ticks, paused, input ready);
  modport sink   (input valid, action, task_id, delay_ticks, paused, output ready);
endinterface

interface sotq_out_if;
  logic                        valid;
  logic                        ready;
  logic                        fired;
  logic [sotq_pkg::TidW-1:0]   fired_task;
  logic                        add_accepted;
  logic [sotq_pkg::PendW-1:0]  pending_count;
  logic [sotq_pkg::DelayW-1:0] tick_total;

  modport source (output valid, fired, fired_task, add_accepted, pending_count, tick_total,
                  input ready);
  modport sink   (input valid, fired, fired_task, add_accepted, pending_count, tick_total,
                  output ready);
endinterface

`default_nettype wire

/* hdl/sorted_oneshot_timer_queue_top.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Sorted one-shot timer queue. Tasks (id, delay) sit in a single-port-write,
// single-port-read memory of DEPTH entries kept in ascending delay order, and a
// small sequencer walks that memory one entry per cycle through one shared
// compare/decrement path. An add moves each entry of larger delay up one slot
// and writes the new task (refused at once when full); an unpaused tick on a
// non-empty queue releases the head if due and rewrites each pending task,
// and a paused tick or one on an empty queue goes straight to its result. The
// input is not ready until the current item's result is in the output register,
// which holds it until taken while the next item is already being worked on.
module sorted_oneshot_timer_queue_top #(
  parameter int unsigned DEPTH = 16
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  sotq_in_if.sink          in_i,
  sotq_out_if.source       out_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);
  localparam logic [CW-1:0] OneC   = CW'(1);

  sotq_pkg::state_e state_q, state_d;

  sotq_pkg::entry_t mem_q [DEPTH];
  sotq_pkg::entry_t rdata_q;
  logic             re, we;
  logic [AW-1:0]    raddr, waddr;
  sotq_pkg::entry_t wdata;

  logic [CW-1:0]              count_q, count_d;
  logic [CW-1:0]              wr_idx_q, wr_idx_d;
  logic                       off_q, off_d;
  logic [sotq_pkg::DelayW-1:0] tick_q, tick_d;
  logic [sotq_pkg::TidW-1:0]   id_q, id_d;
  logic [sotq_pkg::DelayW-1:0] delay_q, delay_d;
  logic                       fired_q, fired_d;
  logic [sotq_pkg::TidW-1:0]   ftask_q, ftask_d;
  logic                       acc_q, acc_d;

  logic                        ov_q, ov_d;
  logic                        o_fired_q, o_fired_d;
  logic [sotq_pkg::TidW-1:0]   o_ftask_q, o_ftask_d;
  logic                        o_acc_q, o_acc_d;
  logic [sotq_pkg::PendW-1:0]  o_pend_q, o_pend_d;
  logic [sotq_pkg::DelayW-1:0] o_tick_q, o_tick_d;

  logic                in_fire;
  logic                head_due;
  logic [CW-1:0]       head_cnt;
  logic [CW:0]         next_rd;

  assign in_i.ready = (state_q == sotq_pkg::ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign head_due   = (rdata_q.delay == '0);
  assign head_cnt   = count_q - CW'(head_due);
  assign next_rd    = {1'b0, wr_idx_q} + (CW+1)'(1) + (CW+1)'(off_q);

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    wr_idx_d = wr_idx_q;
    off_d    = off_q;
    tick_d   = tick_q;
    id_d     = id_q;
    delay_d  = delay_q;
    fired_d  = fired_q;
    ftask_d  = ftask_q;
    acc_d    = acc_q;
    re       = 1'b0;
    raddr    = '0;
    we       = 1'b0;
    waddr    = '0;
    wdata    = rdata_q;

    ov_d      = ov_q && !out_o.ready;
    o_fired_d = o_fired_q;
    o_ftask_d = o_ftask_q;
    o_acc_d   = o_acc_q;
    o_pend_d  = o_pend_q;
    o_tick_d  = o_tick_q;

    unique case (state_q)
      sotq_pkg::ST_IDLE: begin
        if (in_fire) begin
          id_d    = in_i.task_id;
          delay_d = in_i.delay_ticks;
          fired_d = 1'b0;
          ftask_d = '0;
          acc_d   = 1'b0;
          if (in_i.action == sotq_pkg::ActAdd) begin
            priority if (count_q == DepthC) begin
              state_d = sotq_pkg::ST_DONE;
            end else if (count_q == '0) begin
              wr_idx_d = '0;
              state_d  = sotq_pkg::ST_IFIN;
            end else begin
              // fetch the tail entry and walk down from the free slot
              wr_idx_d = count_q;
              re       = 1'b1;
              raddr    = AW'(count_q - OneC);
              state_d  = sotq_pkg::ST_IWALK;
            end
          end else begin
            tick_d = tick_q + 32'd1;
            if (in_i.paused || count_q == '0) begin
              state_d = sotq_pkg::ST_DONE;
            end else begin
              re      = 1'b1;
              raddr   = '0;
              state_d = sotq_pkg::ST_HEAD;
            end
          end
        end
      end

      sotq_pkg::ST_HEAD: begin
        fired_d  = head_due;
        ftask_d  = head_due ? rdata_q.tid : '0;
        off_d    = head_due;
        count_d  = head_cnt;
        wr_idx_d = '0;
        if (head_cnt == '0) begin
          state_d = sotq_pkg::ST_DONE;
        end else begin
          // skip the released head while compacting
          re      = 1'b1;
          raddr   = AW'(head_due);
          state_d = sotq_pkg::ST_TWALK;
        end
      end

      sotq_pkg::ST_TWALK: begin
        we          = 1'b1;
        waddr       = wr_idx_q[AW-1:0];
        wdata.tid   = rdata_q.tid;
        wdata.delay = head_due ? rdata_q.delay : rdata_q.delay - 32'd1;
        wr_idx_d    = wr_idx_q + OneC;
        if (wr_idx_q == count_q - OneC) begin
          state_d = sotq_pkg::ST_DONE;
        end else begin
          re    = 1'b1;
          raddr = next_rd[AW-1:0];
        end
      end

      sotq_pkg::ST_IWALK: begin
        if (rdata_q.delay > delay_q) begin
          // move the larger entry up one slot
          we       = 1'b1;
          waddr    = wr_idx_q[AW-1:0];
          wdata    = rdata_q;
          wr_idx_d = wr_idx_q - OneC;
          if (wr_idx_q == OneC) begin
            state_d = sotq_pkg::ST_IFIN;
          end else begin
            re    = 1'b1;
            raddr = AW'(wr_idx_q - CW'(2));
          end
        end else begin
          we          = 1'b1;
          waddr       = wr_idx_q[AW-1:0];
          wdata.tid   = id_q;
          wdata.delay = delay_q;
          count_d     = count_q + OneC;
          acc_d       = 1'b1;
          state_d     = sotq_pkg::ST_DONE;
        end
      end

      sotq_pkg::ST_IFIN: begin
        we          = 1'b1;
        waddr       = wr_idx_q[AW-1:0];
        wdata.tid   = id_q;
        wdata.delay = delay_q;
        count_d     = count_q + OneC;
        acc_d       = 1'b1;
        state_d     = sotq_pkg::ST_DONE;
      end

      sotq_pkg::ST_DONE: begin
        if (!ov_q || out_o.ready) begin
          ov_d      = 1'b1;
          o_fired_d = fired_q;
          o_ftask_d = ftask_q;
          o_acc_d   = acc_q;
          o_pend_d  = sotq_pkg::PendW'(count_q);
          o_tick_d  = tick_q;
          state_d   = sotq_pkg::ST_IDLE;
        end
      end

      default: state_d = sotq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sotq_pkg::ST_IDLE;
      count_q <= '0;
      tick_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      tick_q  <= tick_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_idx_q  <= wr_idx_d;
    off_q     <= off_d;
    id_q      <= id_d;
    delay_q   <= delay_d;
    fired_q   <= fired_d;
    ftask_q   <= ftask_d;
    acc_q     <= acc_d;
    o_fired_q <= o_fired_d;
    o_ftask_q <= o_ftask_d;
    o_acc_q   <= o_acc_d;
    o_pend_q  <= o_pend_d;
    o_tick_q  <= o_tick_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  assign out_o.valid         = ov_q;
  assign out_o.fired         = o_fired_q;
  assign out_o.fired_task    = o_ftask_q;
  assign out_o.add_accepted  = o_acc_q;
  assign out_o.pending_count = o_pend_q;
  assign out_o.tick_total    = o_tick_q;

  `SOTQ_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= DepthC, "entry count above depth")
  `SOTQ_ASSERT(a_waddr_range, clk_i, rst_ni,
               !we || ({1'b0, waddr} < (AW+1)'(DEPTH)), "write out of range")
  `SOTQ_ASSERT(a_fire_xor_add, clk_i, rst_ni,
               !(out_o.valid && out_o.fired && out_o.add_accepted), "fired and accepted together")
  `SOTQ_ASSERT(a_load_done, clk_i, rst_ni,
               $rose(ov_q) |-> $past(state_q) == sotq_pkg::ST_DONE, "result loaded outside done")

endmodule

`default_nettype wire

/* tb/sv/sorted_oneshot_timer_queue_top_tb.sv */
`timescale 1ns / 1ps

module sorted_oneshot_timer_queue_top_tb;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned ITEMS_PHASE = 150;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_WAIT  = 40;

  typedef struct packed {
    logic                        act;
    logic [sotq_pkg::TidW-1:0]   tid;
    logic [sotq_pkg::DelayW-1:0] delay;
    logic                        paused;
  } timer_cmd_t;

  typedef struct packed {
    logic                        fired;
    logic [sotq_pkg::TidW-1:0]   fired_task;
    logic                        add_ok;
    logic [sotq_pkg::PendW-1:0]  pending;
    logic [sotq_pkg::DelayW-1:0] ticks;
  } timer_status_t;

  logic clk_i;
  logic rst_ni;

  sotq_in_if  in_if ();
  sotq_out_if out_if ();

  sorted_oneshot_timer_queue_top #(
    .DEPTH(DEPTH)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // shadow copy of the sorted task store
  logic [sotq_pkg::DelayW-1:0] slot_delay [DEPTH];
  logic [sotq_pkg::TidW-1:0]   slot_tid   [DEPTH];
  int unsigned                 slot_cnt = 0;
  logic [sotq_pkg::DelayW-1:0] tick_cnt = '0;

  timer_cmd_t    cmd_pending [$];
  timer_status_t status_due  [$];
  timer_cmd_t    cur_cmd;
  timer_status_t got_status;
  timer_status_t want_status;

  int          tx_idle_pct [3] = '{24, 56, 0};
  int          rx_idle_pct [3] = '{56, 24, 0};
  int          idle_mode;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;
  int unsigned err_cnt      = 0;
  int unsigned quiet_cycles = 0;

  function automatic timer_status_t step_timer_queue(timer_cmd_t c);
    timer_status_t s;
    int unsigned   pos;
    s = '0;
    if (c.act == sotq_pkg::ActAdd) begin
      if (slot_cnt < DEPTH) begin
        pos = 0;
        // equal delays keep arrival order: insert after them
        while (pos < slot_cnt && slot_delay[pos] <= c.delay) pos++;
        for (int unsigned k = slot_cnt; k > pos; k--) begin
          slot_delay[k] = slot_delay[k-1];
          slot_tid[k]   = slot_tid[k-1];
        end
        slot_delay[pos] = c.delay;
        slot_tid[pos]   = c.tid;
        slot_cnt++;
        s.add_ok = 1'b1;
      end
    end else begin
      tick_cnt = tick_cnt + 1'b1;
      if (!c.paused) begin
        if (slot_cnt > 0 && slot_delay[0] == '0) begin
          s.fired      = 1'b1;
          s.fired_task = slot_tid[0];
          for (int unsigned k = 1; k < slot_cnt; k++) begin
            slot_delay[k-1] = slot_delay[k];
            slot_tid[k-1]   = slot_tid[k];
          end
          slot_cnt--;
        end
        // saturating countdown
        for (int unsigned k = 0; k < slot_cnt; k++) begin
          if (slot_delay[k] != '0) slot_delay[k] = slot_delay[k] - 1'b1;
        end
      end
    end
    s.pending = slot_cnt[sotq_pkg::PendW-1:0];
    s.ticks   = tick_cnt;
    return s;
  endfunction

  function automatic timer_cmd_t rand_cmd(int add_pct);
    timer_cmd_t c;
    c.act    = ($urandom_range(99) < add_pct) ? sotq_pkg::ActAdd : sotq_pkg::ActTick;
    c.tid    = sotq_pkg::TidW'($urandom);
    c.paused = ($urandom_range(99) < 20);
    case ($urandom_range(9))
      0:       c.delay = $urandom;
      1:       c.delay = 32'hFFFF_FFFF - $urandom_range(3);
      2, 3:    c.delay = '0;
      default: c.delay = $urandom_range(24);
    endcase
    return c;
  endfunction

  task automatic push_cmd(logic act, logic [sotq_pkg::TidW-1:0] tid,
                          logic [sotq_pkg::DelayW-1:0] delay, logic paused);
    timer_cmd_t c;
    c.act    = act;
    c.tid    = tid;
    c.delay  = delay;
    c.paused = paused;
    cmd_pending.push_back(c);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // driver: hold an offered item until it is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid       <= 1'b0;
      in_if.action      <= sotq_pkg::ActTick;
      in_if.task_id     <= '0;
      in_if.delay_ticks <= '0;
      in_if.paused      <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) status_due.push_back(step_timer_queue(cur_cmd));
      if (!in_if.valid || in_if.ready) begin
        if (cmd_pending.size() != 0 && $urandom_range(99) >= tx_idle_pct[idle_mode]) begin
          cur_cmd = cmd_pending.pop_front();
          in_if.valid       <= 1'b1;
          in_if.action      <= cur_cmd.act;
          in_if.task_id     <= cur_cmd.tid;
          in_if.delay_ticks <= cur_cmd.delay;
          in_if.paused      <= cur_cmd.paused;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got_status.fired      = out_if.fired;
        got_status.fired_task = out_if.fired_task;
        got_status.add_ok     = out_if.add_accepted;
        got_status.pending    = out_if.pending_count;
        got_status.ticks      = out_if.tick_total;
        if (status_due.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result, actual %h", $time, got_status);
        end else begin
          want_status = status_due.pop_front();
          if (got_status.fired !== want_status.fired) begin
            err_cnt++;
            $display("%0t: fired expected %h actual %h", $time,
                     want_status.fired, got_status.fired);
          end
          if (got_status.fired_task !== want_status.fired_task) begin
            err_cnt++;
            $display("%0t: fired_task expected %h actual %h", $time,
                     want_status.fired_task, got_status.fired_task);
          end
          if (got_status.add_ok !== want_status.add_ok) begin
            err_cnt++;
            $display("%0t: add_accepted expected %h actual %h", $time,
                     want_status.add_ok, got_status.add_ok);
          end
          if (got_status.pending !== want_status.pending) begin
            err_cnt++;
            $display("%0t: pending_count expected %0d actual %0d", $time,
                     want_status.pending, got_status.pending);
          end
          if (got_status.ticks !== want_status.ticks) begin
            err_cnt++;
            $display("%0t: tick_total expected %h actual %h", $time,
                     want_status.ticks, got_status.ticks);
          end
        end
      end
      // hold off once for a long stretch so the block fills up
      if (idle_mode == 1 && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rx_idle_pct[idle_mode]);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
          $display("sorted_oneshot_timer_queue_top_tb NOT OK");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_ni    = 1'b0;
    idle_mode = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty queue, unpaused and paused
    push_cmd(sotq_pkg::ActTick, 8'h5A, 32'hFFFF_FFFF, 1'b0);
    push_cmd(sotq_pkg::ActTick, 8'h00, 32'h0000_0000, 1'b1);
    // fill with extremes, ties and several due tasks
    push_cmd(sotq_pkg::ActAdd, 8'hFF, 32'h0000_0000, 1'b1);
    push_cmd(sotq_pkg::ActAdd, 8'h00, 32'h0000_0000, 1'b0);
    push_cmd(sotq_pkg::ActAdd, 8'h11, 32'hFFFF_FFFF, 1'b0);
    push_cmd(sotq_pkg::ActAdd, 8'h22, 32'h0000_0001, 1'b1);
    push_cmd(sotq_pkg::ActAdd, 8'h33, 32'h0000_0001, 1'b0);
    push_cmd(sotq_pkg::ActAdd, 8'h44, 32'hFFFF_FFFE, 1'b0);
    push_cmd(sotq_pkg::ActAdd, 8'h55, 32'h0000_0000, 1'b0);
    push_cmd(sotq_pkg::ActAdd, 8'h66, 32'h0000_0002, 1'b0);
    for (int i = 0; i < 8; i++) begin
      push_cmd(sotq_pkg::ActAdd, sotq_pkg::TidW'(8'h70 + i), sotq_pkg::DelayW'(3 * i), i[0]);
    end
    // full: refused
    push_cmd(sotq_pkg::ActAdd, 8'hAB, 32'h0000_0005, 1'b0);
    // paused tick with the head due
    push_cmd(sotq_pkg::ActTick, 8'hC3, 32'h8000_0000, 1'b1);
    repeat (4) push_cmd(sotq_pkg::ActTick, 8'h00, 32'h0000_0000, 1'b0);

    for (int ph = 0; ph < 3; ph++) begin
      idle_mode = ph;
      for (int n = 0; n < ITEMS_PHASE; n++) begin
        cmd_pending.push_back(rand_cmd(((n / 50) % 2) ? 35 : 70));
      end
      while (cmd_pending.size() != 0 || in_if.valid) @(negedge clk_i);
    end

    while (status_due.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("sorted_oneshot_timer_queue_top_tb OK");
    end else begin
      $display("sorted_oneshot_timer_queue_top_tb NOT OK");
    end
    $finish;
  end

endmodule
